// ----- rtl/lts_pkg.sv -----
// ----------------------------------------------------------------------------
// LCD text glyph streamer package
// Item types, action codes, font constants and the 5x7 glyph table.
// ----------------------------------------------------------------------------
package lts_pkg;

   localparam int GLYPH_COLUMNS = 5;
   localparam int CELL_WIDTH    = 6;
   localparam int GLYPH_COUNT   = 90;
   localparam int IDX_W         = $clog2(CELL_WIDTH);

   localparam logic [1:0] ACT_GOTO   = 2'd0;
   localparam logic [1:0] ACT_LOCATE = 2'd1;
   localparam logic [1:0] ACT_PRINT  = 2'd2;

   localparam logic [7:0] SYM_SPACE      = 8'h20;
   localparam logic [7:0] SYM_FIRST      = 8'h21;
   localparam logic [7:0] SYM_LAST_GLYPH = 8'(8'h21 + GLYPH_COUNT - 1);
   localparam logic [7:0] SYM_END        = 8'hA0;

   localparam logic [3:0] CMD_PAGE_HI = 4'hB;
   localparam logic [4:0] CMD_COL_HI  = 5'b00010;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] row;
      logic [7:0] column;
      logic [7:0] symbol;
      logic [2:0] style;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_data;
      logic       last;
      logic [7:0] cursor_column;
      logic [3:0] cursor_page;
   } rsp_type;

   typedef struct packed {
      logic [CELL_WIDTH-1:0][7:0] bytes;
      logic [IDX_W-1:0]           last_idx;
      logic                       is_data;
      logic [7:0]                 cursor_column;
      logic [3:0]                 cursor_page;
      logic                       emit;
   } job_type;

   typedef logic [0:GLYPH_COLUMNS-1][7:0] glyph_type;

   function automatic glyph_type glyph_lookup(input logic [6:0] idx);
      glyph_type g;
      unique case (idx)
         7'd0:  g = 40'h0E5F0E0000;
         7'd1:  g = 40'h060E000E06;
         7'd2:  g = 40'h247E247E24;
         7'd3:  g = 40'h242A7F2A12;
         7'd4:  g = 40'h4424104844;
         7'd5:  g = 40'h344A5A2450;
         7'd6:  g = 40'h0806000000;
         7'd7:  g = 40'h0000003E41;
         7'd8:  g = 40'h413E000000;
         7'd9:  g = 40'h0A041F040A;
         7'd10: g = 40'h10107C1010;
         7'd11: g = 40'h8040000000;
         7'd12: g = 40'h1010101010;
         7'd13: g = 40'h0040400000;
         7'd14: g = 40'h4020100804;
         7'd15: g = 40'h3E5149453E;
         7'd16: g = 40'h00427F4000;
         7'd17: g = 40'h4261514946;
         7'd18: g = 40'h2249494936;
         7'd19: g = 40'h1814527F50;
         7'd20: g = 40'h2745454539;
         7'd21: g = 40'h3E49494932;
         7'd22: g = 40'h0301611907;
         7'd23: g = 40'h3649494936;
         7'd24: g = 40'h264949493E;
         7'd25: g = 40'h4444000000;
         7'd26: g = 40'h8444000000;
         7'd27: g = 40'h0008142241;
         7'd28: g = 40'h2424242424;
         7'd29: g = 40'h4122140800;
         7'd30: g = 40'h0201510906;
         7'd31: g = 40'h3E4159591E;
         7'd32: g = 40'h7E0909097E;
         7'd33: g = 40'h7F49494936;
         7'd34: g = 40'h3E41414122;
         7'd35: g = 40'h7F4141413E;
         7'd36: g = 40'h7F49494941;
         7'd37: g = 40'h7F09090901;
         7'd38: g = 40'h3E41515132;
         7'd39: g = 40'h7F0808087F;
         7'd40: g = 40'h00417F4100;
         7'd41: g = 40'h214141413F;
         7'd42: g = 40'h7F10284443;
         7'd43: g = 40'h7F40404060;
         7'd44: g = 40'h7F0618067F;
         7'd45: g = 40'h7F0608307F;
         7'd46: g = 40'h3E4141413E;
         7'd47: g = 40'h7F09090906;
         7'd48: g = 40'h3E4171613E;
         7'd49: g = 40'h7F09192946;
         7'd50: g = 40'h2649494932;
         7'd51: g = 40'h03017F0103;
         7'd52: g = 40'h3F4040403F;
         7'd53: g = 40'h1F2040201F;
         7'd54: g = 40'h3F4038403F;
         7'd55: g = 40'h6314081463;
         7'd56: g = 40'h274848483F;
         7'd57: g = 40'h6351494563;
         7'd58: g = 40'h0000007F41;
         7'd59: g = 40'h0408102040;
         7'd60: g = 40'h417F000000;
         7'd61: g = 40'h306030180C;
         7'd62: g = 40'h4040404040;
         7'd63: g = 40'h013C424224;
         7'd64: g = 40'h2054541478;
         7'd65: g = 40'h7F28444438;
         7'd66: g = 40'h3844444428;
         7'd67: g = 40'h384444287F;
         7'd68: g = 40'h3854545408;
         7'd69: g = 40'h107C121202;
         7'd70: g = 40'h4C5252523C;
         7'd71: g = 40'h7F04040478;
         7'd72: g = 40'h00487A4000;
         7'd73: g = 40'h00887A0000;
         7'd74: g = 40'h7F10284400;
         7'd75: g = 40'h00417F4000;
         7'd76: g = 40'h7C04780478;
         7'd77: g = 40'h7C08040478;
         7'd78: g = 40'h3844444438;
         7'd79: g = 40'hFE2422221C;
         7'd80: g = 40'h1C222224FE;
         7'd81: g = 40'h7C08040408;
         7'd82: g = 40'h4854545424;
         7'd83: g = 40'h00047E4400;
         7'd84: g = 40'h3C4040407C;
         7'd85: g = 40'h1C2040201C;
         7'd86: g = 40'h3C4030403C;
         7'd87: g = 40'h4428102844;
         7'd88: g = 40'h0C5050503C;
         7'd89: g = 40'h645454544C;
         default: g = '0;
      endcase
      return g;
   endfunction

endpackage

// ----- rtl/lts_decode.sv -----
// ----------------------------------------------------------------------------
// LCD text glyph streamer decoder
// Turns one item and the current cursor into the bytes it emits.
// ----------------------------------------------------------------------------
module lts_decode
   import lts_pkg::*;
(
   input  req_type    req_data,
   input  logic [7:0] cursor_x,
   input  logic [3:0] cursor_y,
   output job_type    job
);

   logic [7:0] addr_col;
   logic [7:0] loc_col;
   logic [7:0] glyph_off;
   logic       glyph_ok;
   logic       print_ok;
   glyph_type  glyph;
   logic [7:0] col;

   assign loc_col   = 8'({4'd0, req_data.column[3:0]} * 8'(CELL_WIDTH));
   assign glyph_off = req_data.symbol - SYM_FIRST;
   assign glyph_ok  = (req_data.symbol >= SYM_FIRST) && (req_data.symbol <= SYM_LAST_GLYPH);
   assign glyph     = glyph_lookup(glyph_off[6:0]);
   assign print_ok  = !req_data.style[2] && (req_data.symbol >= SYM_SPACE)
                      && (req_data.symbol < SYM_END);

   always_comb begin
      job          = '0;
      addr_col     = req_data.column;
      col          = '0;
      unique case (req_data.action)
         ACT_GOTO, ACT_LOCATE: begin
            addr_col = (req_data.action == ACT_GOTO) ? req_data.column : loc_col;
            job.bytes[0]      = {CMD_PAGE_HI, req_data.row[3:0]};
            job.bytes[1]      = {4'd0, addr_col[3:0]};
            job.bytes[2]      = {CMD_COL_HI, addr_col[6:4]};
            job.last_idx      = IDX_W'(2);
            job.is_data       = 1'b0;
            job.cursor_column = (req_data.action == ACT_GOTO) ?
                                {1'b0, req_data.column[6:0]} : loc_col;
            job.cursor_page   = req_data.row[3:0];
            job.emit          = 1'b1;
         end
         ACT_PRINT: begin
            for (int k = 0; k < CELL_WIDTH; k++) begin
               col = '0;
               if (k < GLYPH_COLUMNS && glyph_ok)
                  col = glyph[k];
               if (req_data.style[1])
                  col = '0;
               if (req_data.style[0])
                  col = ~col;
               job.bytes[k] = col;
            end
            job.last_idx      = IDX_W'(CELL_WIDTH - 1);
            job.is_data       = 1'b1;
            job.cursor_column = cursor_x + 8'(CELL_WIDTH);
            job.cursor_page   = cursor_y;
            job.emit          = print_ok;
         end
         default: begin
            job.emit = 1'b0;
         end
      endcase
   end

endmodule

// ----- rtl/lts_emitter.sv -----
// ----------------------------------------------------------------------------
// LCD text glyph streamer emitter
// Holds the decoded item and sends its bytes through a result register.
// ----------------------------------------------------------------------------
module lts_emitter
   import lts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  job_type job_in,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   job_type          job_ff, job_in_nxt;
   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   rsp_type          out_ff, out_in;
   logic             valid_ff, valid_in;
   logic             out_ready;
   logic             move;
   logic             job_done;
   logic             accept;

   assign out_ready = !valid_ff || !rsp_stall;
   assign move      = busy_ff && out_ready;
   assign job_done  = move && (idx_ff == job_ff.last_idx);
   assign req_stall = busy_ff && !job_done;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      busy_in    = busy_ff;
      idx_in     = idx_ff;
      job_in_nxt = job_ff;
      out_in     = out_ff;
      valid_in   = valid_ff && rsp_stall;
      if (move) begin
         out_in.out_byte      = job_ff.bytes[idx_ff];
         out_in.is_data       = job_ff.is_data;
         out_in.last          = (idx_ff == job_ff.last_idx);
         out_in.cursor_column = job_ff.cursor_column;
         out_in.cursor_page   = job_ff.cursor_page;
         valid_in             = 1'b1;
         idx_in               = idx_ff + IDX_W'(1);
      end
      if (job_done)
         busy_in = 1'b0;
      if (accept) begin
         busy_in    = job_in.emit;
         idx_in     = '0;
         job_in_nxt = job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      job_ff <= job_in_nxt;
      out_ff <= out_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ----- rtl/lcd_text_glyph_streamer_top.sv -----
// An accepted item is held in the emitter's job register, then sent out byte by byte.
// Throughput: one byte per cycle out of the single result register while rsp_stall
// is low; goto and locate emit 3 bytes, print emits 6, items that emit nothing none.
// The next item is accepted in the cycle the current item's last byte is registered.
// Reset clears the cursor to column 0, page 0 and empties the emitter.
// ----------------------------------------------------------------------------
// LCD text glyph streamer
// Cursor-tracking 5x7 text front end emitting controller command and data bytes.
// ----------------------------------------------------------------------------
module lcd_text_glyph_streamer_top
   import lts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [7:0] cursor_x_ff, cursor_x_in;
   logic [3:0] cursor_y_ff, cursor_y_in;
   job_type    job;
   logic       accept;

   lts_decode u_decode (
      .req_data (req_data),
      .cursor_x (cursor_x_ff),
      .cursor_y (cursor_y_ff),
      .job      (job)
   );

   lts_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .job_in    (job),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign accept = req_valid && !req_stall;

   always_comb begin
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      if (accept && job.emit) begin
         cursor_x_in = job.cursor_column;
         cursor_y_in = job.cursor_page;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
      end else begin
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
      end
   end

   // cursor moves only on an accepted item
   a_cursor_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(cursor_x_ff) && $stable(cursor_y_ff))
      else $error("cursor changed without an accepted item");

   // the last command byte of an address sequence is the column high command
   a_cmd_tail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.is_data && rsp_data.last)
         |-> (rsp_data.out_byte[7:3] == CMD_COL_HI))
      else $error("address sequence ended on a wrong command");

   // the first command byte of an address sequence is never flagged last
   a_cmd_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.is_data && (rsp_data.out_byte[7:4] == CMD_PAGE_HI))
         |-> !rsp_data.last)
      else $error("page command flagged as last byte");

endmodule

// ----- bench/lcd_text_glyph_streamer_check.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LCD text glyph streamer checker
// Watches the req and rsp channels. It tracks its own cursor and font table
// to work out the command or data bytes of every accepted item. Each
// accepted rsp item is compared field by field with the oldest one due.
// ----------------------------------------------------------------------------
module lcd_text_glyph_streamer_check
   import lts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      failures,
   output int      pending
);

   // one 40-bit entry per glyph, leftmost column in the top byte
   localparam logic [0:GLYPH_COUNT-1][39:0] FONT_5X7 = {
      40'h0E5F0E0000, 40'h060E000E06, 40'h247E247E24, 40'h242A7F2A12, 40'h4424104844,
      40'h344A5A2450, 40'h0806000000, 40'h0000003E41, 40'h413E000000, 40'h0A041F040A,
      40'h10107C1010, 40'h8040000000, 40'h1010101010, 40'h0040400000, 40'h4020100804,
      40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2249494936, 40'h1814527F50,
      40'h2745454539, 40'h3E49494932, 40'h0301611907, 40'h3649494936, 40'h264949493E,
      40'h4444000000, 40'h8444000000, 40'h0008142241, 40'h2424242424, 40'h4122140800,
      40'h0201510906, 40'h3E4159591E, 40'h7E0909097E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E41515132, 40'h7F0808087F,
      40'h00417F4100, 40'h214141413F, 40'h7F10284443, 40'h7F40404060, 40'h7F0618067F,
      40'h7F0608307F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4171613E, 40'h7F09192946,
      40'h2649494932, 40'h03017F0103, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
      40'h6314081463, 40'h274848483F, 40'h6351494563, 40'h0000007F41, 40'h0408102040,
      40'h417F000000, 40'h306030180C, 40'h4040404040, 40'h013C424224, 40'h2054541478,
      40'h7F28444438, 40'h3844444428, 40'h384444287F, 40'h3854545408, 40'h107C121202,
      40'h4C5252523C, 40'h7F04040478, 40'h00487A4000, 40'h00887A0000, 40'h7F10284400,
      40'h00417F4000, 40'h7C04780478, 40'h7C08040478, 40'h3844444438, 40'hFE2422221C,
      40'h1C222224FE, 40'h7C08040408, 40'h4854545424, 40'h00047E4400, 40'h3C4040407C,
      40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C, 40'h645454544C
   };

   logic [7:0] pen_column;
   logic [3:0] pen_page;
   rsp_type    due_bytes [$];
   rsp_type    want;

   task automatic push_byte(input logic [7:0] value, input logic data, input logic tail);
      rsp_type b;
      b.out_byte      = value;
      b.is_data       = data;
      b.last          = tail;
      b.cursor_column = pen_column;
      b.cursor_page   = pen_page;
      due_bytes.push_back(b);
   endtask

   task automatic render_item(input req_type item);
      logic [7:0] addr;
      logic [7:0] col;
      int         g;
      case (item.action)
         ACT_GOTO, ACT_LOCATE: begin
            if (item.action == ACT_GOTO)
               addr = {1'b0, item.column[6:0]};
            else
               addr = 8'(item.column[3:0] * CELL_WIDTH);
            pen_column = addr;
            pen_page   = item.row[3:0];
            push_byte({CMD_PAGE_HI, item.row[3:0]}, 1'b0, 1'b0);
            push_byte({4'h0, addr[3:0]}, 1'b0, 1'b0);
            push_byte({CMD_COL_HI, addr[6:4]}, 1'b0, 1'b1);
         end
         ACT_PRINT: begin
            if (!item.style[2] && item.symbol >= SYM_SPACE && item.symbol < SYM_END) begin
               pen_column = 8'(pen_column + CELL_WIDTH);
               g = int'(item.symbol) - int'(SYM_FIRST);
               for (int k = 0; k < CELL_WIDTH; k++) begin
                  col = 8'h00;
                  if (g >= 0 && g < GLYPH_COUNT && k < GLYPH_COLUMNS)
                     col = FONT_5X7[g][8*(GLYPH_COLUMNS-1-k) +: 8];
                  if (item.style[1])
                     col = 8'h00;
                  if (item.style[0])
                     col = ~col;
                  push_byte(col, 1'b1, k == CELL_WIDTH - 1);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input int exp_v, input int got_v);
      if (exp_v != got_v) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pen_column = 8'h00;
         pen_page   = 4'h0;
         due_bytes.delete();
         failures   = 0;
         pending   <= 0;
      end else begin
         if (req_valid && !req_stall)
            render_item(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (due_bytes.size() == 0) begin
               $error("unexpected rsp item: out_byte %0h", rsp_data.out_byte);
               failures++;
            end else begin
               want = due_bytes.pop_front();
               check_field("out_byte", want.out_byte, rsp_data.out_byte);
               check_field("is_data", want.is_data, rsp_data.is_data);
               check_field("last", want.last, rsp_data.last);
               check_field("cursor_column", want.cursor_column, rsp_data.cursor_column);
               check_field("cursor_page", want.cursor_page, rsp_data.cursor_page);
            end
         end
         pending <= due_bytes.size();
      end
   end

endmodule

// ----- bench/lcd_text_glyph_streamer_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LCD text glyph streamer testbench
// Drives goto, locate, print and unused-action items with random gaps and rsp back-pressure,
// a directed pass over the font edges and styles, then random traffic.
// ----------------------------------------------------------------------------
module lcd_text_glyph_streamer_top_test;
   import lts_pkg::*;

   localparam logic [1:0] ACT_UNUSED   = 2'd3;
   localparam int         RANDOM_ITEMS = 237;
   localparam int         CYCLE_LIMIT  = 200000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      failures;
   int      pending;
   int      cycle_count = 0;
   logic    calm = 1'b0;

   lcd_text_glyph_streamer_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   lcd_text_glyph_streamer_check u_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .failures  (failures),
      .pending   (pending)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      if (!reset)
         rsp_stall <= !calm && ($urandom_range(99) < 34);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL lcd_text_glyph_streamer_top");
         $finish;
      end
   end

   task automatic offer_item(input req_type item);
      if (!calm && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_fields(input logic [1:0] act, input logic [7:0] r, input logic [7:0] c,
                              input logic [7:0] s, input logic [2:0] st);
      req_type item;
      item.action = act;
      item.row    = r;
      item.column = c;
      item.symbol = s;
      item.style  = st;
      offer_item(item);
   endtask

   task automatic drain_bytes();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic req_type random_item();
      req_type item;
      int      pick;
      item.action = ACT_PRINT;
      item.row    = 8'($urandom);
      item.column = 8'($urandom);
      item.symbol = 8'($urandom_range(8'h20, 8'h9F));
      item.style  = 3'($urandom_range(0, 3));
      pick = $urandom_range(99);
      if (pick < 12) begin
         item.action = ACT_GOTO;
      end else if (pick < 24) begin
         item.action = ACT_LOCATE;
      end else if (pick < 34) begin
         item.symbol = 8'($urandom);
         item.style  = 3'($urandom);
      end else if (pick < 38) begin
         item.action = ACT_UNUSED;
      end
      return item;
   endfunction

   initial begin
      req_type item;
      int      made;
      made = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_fields(ACT_GOTO, 8'h00, 8'h00, 8'h00, 3'd0);
      send_fields(ACT_GOTO, 8'hFF, 8'hFF, 8'hFF, 3'd7);
      send_fields(ACT_PRINT, 8'h00, 8'h00, 8'h41, 3'd0);
      send_fields(ACT_PRINT, 8'h00, 8'h00, SYM_SPACE, 3'd0);
      send_fields(ACT_PRINT, 8'h00, 8'h00, SYM_FIRST, 3'd0);
      send_fields(ACT_PRINT, 8'h00, 8'h00, SYM_LAST_GLYPH, 3'd0);
      send_fields(ACT_PRINT, 8'h00, 8'h00, 8'h7B, 3'd0);
      send_fields(ACT_PRINT, 8'h00, 8'h00, 8'h9F, 3'd0);
      send_fields(ACT_PRINT, 8'h00, 8'h00, 8'h1F, 3'd0);
      send_fields(ACT_PRINT, 8'h00, 8'h00, SYM_END, 3'd0);
      send_fields(ACT_PRINT, 8'h00, 8'h00, 8'hFF, 3'd0);
      send_fields(ACT_PRINT, 8'h00, 8'h00, 8'h00, 3'd0);
      send_fields(ACT_PRINT, 8'h00, 8'h00, 8'h48, 3'd1);
      send_fields(ACT_PRINT, 8'h00, 8'h00, 8'h48, 3'd2);
      send_fields(ACT_PRINT, 8'h00, 8'h00, 8'h48, 3'd3);
      send_fields(ACT_PRINT, 8'h00, 8'h00, 8'h48, 3'd4);
      send_fields(ACT_PRINT, 8'h00, 8'h00, SYM_SPACE, 3'd7);
      send_fields(ACT_PRINT, 8'h00, 8'h00, SYM_SPACE, 3'd3);
      send_fields(ACT_LOCATE, 8'h0F, 8'h0F, 8'h00, 3'd0);
      send_fields(ACT_LOCATE, 8'hA5, 8'hFF, 8'h00, 3'd0);
      send_fields(ACT_LOCATE, 8'h00, 8'h00, 8'h00, 3'd0);
      send_fields(ACT_UNUSED, 8'hFF, 8'hFF, 8'h41, 3'd0);
      send_fields(ACT_GOTO, 8'h07, 8'h7F, 8'h00, 3'd0);

      // hold off until every byte of the directed part is out
      drain_bytes();

      while (made < RANDOM_ITEMS) begin
         item = random_item();
         offer_item(item);
         made++;
         calm = (made >= 90 && made < 150);
      end

      drain_bytes();
      repeat (8) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("PASS lcd_text_glyph_streamer_top");
      else
         $display("FAIL lcd_text_glyph_streamer_top");
      $finish;
   end

endmodule
